// ===== design/ps2_mouse_packet_cursor_tracker_core_defines.svh =====
// ----------------------------------------------------------------------------
// PS/2 cursor tracker assertion macros
// Shared concurrent assertion forms for the cursor tracker checkers.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, masked while reset is high
`define PMCT_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, masked while reset is high
`define PMCT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/pmct_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 cursor tracker package
// Types, codes and reset values shared by the tracker and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmct_pkg;

   localparam int unsigned COORD_W = 12;
   localparam int unsigned COLOR_W = 3;
   localparam int unsigned BYTE_W  = 8;

   // configuration register indexes
   typedef enum logic {
      CSR_X_LIMIT = 1'b0,
      CSR_Y_LIMIT = 1'b1
   } csr_index_type;

   localparam logic [COORD_W-1:0] X_LIMIT_RESET = 12'd320;
   localparam logic [COORD_W-1:0] Y_LIMIT_RESET = 12'd200;
   localparam logic [COORD_W-1:0] POS_X_RESET   = 12'd160;
   localparam logic [COORD_W-1:0] POS_Y_RESET   = 12'd100;

   localparam logic [COLOR_W-1:0] COLOR_INIT   = 3'd1;
   localparam logic [COLOR_W-1:0] COLOR_LEFT   = 3'd4;
   localparam logic [COLOR_W-1:0] COLOR_RIGHT  = 3'd5;
   localparam logic [COLOR_W-1:0] COLOR_MIDDLE = 3'd6;

   // header byte bits
   localparam int unsigned HDR_LEFT   = 0;
   localparam int unsigned HDR_RIGHT  = 1;
   localparam int unsigned HDR_MIDDLE = 2;
   localparam int unsigned HDR_SYNC   = 3;
   localparam int unsigned HDR_X_OVF  = 6;
   localparam int unsigned HDR_Y_OVF  = 7;

   typedef enum logic [1:0] {
      OUTCOME_MOVED   = 2'd0,
      OUTCOME_DROPPED = 2'd1,
      OUTCOME_CLICK   = 2'd2
   } outcome_type;

   // which byte of the packet comes next
   typedef enum logic [1:0] {
      POS_HEADER = 2'd0,
      POS_XDELTA = 2'd1,
      POS_YDELTA = 2'd2
   } pos_state_type;

endpackage

`default_nettype wire

// ===== design/ps2_mouse_packet_cursor_tracker_core.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker
// Assembles three-byte mouse packets and tracks cursor position and color.
// ----------------------------------------------------------------------------
// One byte word is taken every clock cycle; the tracker never stalls on its
// own. Bytes with req_from_aux low are dropped with no effect. The third byte
// of a packet produces one result word, visible on rsp_* the cycle after that
// byte is taken; the packet is judged and the cursor clamped by a single
// add-and-compare stage feeding the result register. req_ready falls only
// while a result is held in that register and rsp_ready is low. Limits must be
// written through csr_* only while no packet is pending; not enforced here.
// Reset: cursor (160, 100), color 1, limits 320 by 200; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_cursor_tracker_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // byte channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [pmct_pkg::BYTE_W-1:0]     req_data_byte,
   input  wire logic                            req_from_aux,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [pmct_pkg::COORD_W-1:0]         rsp_cursor_x,
   output logic [pmct_pkg::COORD_W-1:0]         rsp_cursor_y,
   output logic [pmct_pkg::COLOR_W-1:0]         rsp_cursor_color,
   output logic [1:0]                           rsp_outcome,
   // limit registers
   input  wire logic                            csr_wr_en,
   input  wire logic                            csr_index,
   input  wire logic [pmct_pkg::COORD_W-1:0]    csr_wdata
);

   localparam int unsigned SUM_W = pmct_pkg::COORD_W + 2;

   pmct_pkg::pos_state_type           pos_ff, pos_in;
   logic [pmct_pkg::BYTE_W-1:0]       header_ff, header_in;
   logic [pmct_pkg::BYTE_W-1:0]       x_delta_ff, x_delta_in;
   logic [pmct_pkg::COORD_W-1:0]      pos_x_ff, pos_x_in;
   logic [pmct_pkg::COORD_W-1:0]      pos_y_ff, pos_y_in;
   logic [pmct_pkg::COLOR_W-1:0]      color_ff, color_in;
   logic [pmct_pkg::COORD_W-1:0]      x_limit_ff, x_limit_in;
   logic [pmct_pkg::COORD_W-1:0]      y_limit_ff, y_limit_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   pmct_pkg::outcome_type             outcome_ff, outcome_in;

   logic                              accept;
   logic                              aux_word;
   logic                              header_wr;
   logic                              x_delta_wr;
   logic                              packet_done;
   logic signed [SUM_W-1:0]           sum_x;
   logic signed [SUM_W-1:0]           sum_y;
   logic [pmct_pkg::COORD_W-1:0]      clamp_x;
   logic [pmct_pkg::COORD_W-1:0]      clamp_y;

   function automatic logic [pmct_pkg::COORD_W-1:0] clamp_coord(
      input logic signed [SUM_W-1:0]      v,
      input logic [pmct_pkg::COORD_W-1:0] limit
   );
      logic [pmct_pkg::COORD_W-1:0] r;
      if (v[SUM_W-1]) begin
         r = '0;
      end else if (v[SUM_W-2:0] > {1'b0, limit}) begin
         r = limit;
      end else begin
         r = v[pmct_pkg::COORD_W-1:0];
      end
      return r;
   endfunction

   // the result register frees up as soon as its word is taken
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign aux_word   = accept && req_from_aux;

   // next state
   always_comb begin
      pos_in = pos_ff;
      if (aux_word) begin
         case (pos_ff)
            pmct_pkg::POS_HEADER: begin
               pos_in = req_data_byte[pmct_pkg::HDR_SYNC] ? pmct_pkg::POS_XDELTA
                                                           : pmct_pkg::POS_HEADER;
            end
            pmct_pkg::POS_XDELTA: pos_in = pmct_pkg::POS_YDELTA;
            pmct_pkg::POS_YDELTA: pos_in = pmct_pkg::POS_HEADER;
            default: begin
               pos_in = req_data_byte[pmct_pkg::HDR_SYNC] ? pmct_pkg::POS_XDELTA
                                                           : pmct_pkg::POS_HEADER;
            end
         endcase
      end
   end

   // state decode
   always_comb begin
      header_wr   = 1'b0;
      x_delta_wr  = 1'b0;
      packet_done = 1'b0;
      case (pos_ff)
         pmct_pkg::POS_XDELTA: x_delta_wr  = aux_word;
         pmct_pkg::POS_YDELTA: packet_done = aux_word;
         default:              header_wr   = aux_word;
      endcase
   end

   assign sum_x = $signed({2'b00, pos_x_ff})
                + $signed({{(SUM_W-pmct_pkg::BYTE_W){x_delta_ff[pmct_pkg::BYTE_W-1]}},
                           x_delta_ff});
   assign sum_y = $signed({2'b00, pos_y_ff})
                - $signed({{(SUM_W-pmct_pkg::BYTE_W){req_data_byte[pmct_pkg::BYTE_W-1]}},
                           req_data_byte});
   assign clamp_x = clamp_coord(sum_x, x_limit_ff);
   assign clamp_y = clamp_coord(sum_y, y_limit_ff);

   // packet judgment
   always_comb begin
      header_in    = header_wr  ? req_data_byte : header_ff;
      x_delta_in   = x_delta_wr ? req_data_byte : x_delta_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      color_in     = color_ff;
      outcome_in   = outcome_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (packet_done) begin
         rsp_valid_in = 1'b1;
         if (header_ff[pmct_pkg::HDR_Y_OVF] || header_ff[pmct_pkg::HDR_X_OVF]) begin
            outcome_in = pmct_pkg::OUTCOME_DROPPED;
         end else if (header_ff[pmct_pkg::HDR_LEFT]) begin
            color_in   = pmct_pkg::COLOR_LEFT;
            outcome_in = pmct_pkg::OUTCOME_CLICK;
         end else if (header_ff[pmct_pkg::HDR_RIGHT]) begin
            color_in   = pmct_pkg::COLOR_RIGHT;
            outcome_in = pmct_pkg::OUTCOME_CLICK;
         end else if (header_ff[pmct_pkg::HDR_MIDDLE]) begin
            color_in   = pmct_pkg::COLOR_MIDDLE;
            outcome_in = pmct_pkg::OUTCOME_CLICK;
         end else begin
            pos_x_in   = clamp_x;
            pos_y_in   = clamp_y;
            outcome_in = pmct_pkg::OUTCOME_MOVED;
         end
      end
   end

   // limit registers
   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (csr_wr_en) begin
         case (pmct_pkg::csr_index_type'(csr_index))
            pmct_pkg::CSR_X_LIMIT: x_limit_in = csr_wdata;
            pmct_pkg::CSR_Y_LIMIT: y_limit_in = csr_wdata;
            default: begin
               x_limit_in = x_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= pmct_pkg::POS_HEADER;
         header_ff    <= '0;
         x_delta_ff   <= '0;
         pos_x_ff     <= pmct_pkg::POS_X_RESET;
         pos_y_ff     <= pmct_pkg::POS_Y_RESET;
         color_ff     <= pmct_pkg::COLOR_INIT;
         x_limit_ff   <= pmct_pkg::X_LIMIT_RESET;
         y_limit_ff   <= pmct_pkg::Y_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         header_ff    <= header_in;
         x_delta_ff   <= x_delta_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         color_ff     <= color_in;
         x_limit_ff   <= x_limit_in;
         y_limit_ff   <= y_limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only when a packet completes
   always_ff @(posedge clock) begin
      outcome_ff <= outcome_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_x     = pos_x_ff;
   assign rsp_cursor_y     = pos_y_ff;
   assign rsp_cursor_color = color_ff;
   assign rsp_outcome      = outcome_ff;

endmodule

`default_nettype wire

// ===== design/pmct_checker.sv =====
// ----------------------------------------------------------------------------
// PS/2 cursor tracker port checker
// Watches the tracker ports for handshake and result sanity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ps2_mouse_packet_cursor_tracker_core_defines.svh"

module pmct_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            req_from_aux,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [pmct_pkg::COORD_W-1:0]    rsp_cursor_x,
   input wire logic [pmct_pkg::COORD_W-1:0]    rsp_cursor_y,
   input wire logic [pmct_pkg::COLOR_W-1:0]    rsp_cursor_color,
   input wire logic [1:0]                      rsp_outcome
);

   // hold a stalled result word
   `PMCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_cursor_x) && $stable(rsp_cursor_y)
         && $stable(rsp_cursor_color) && $stable(rsp_outcome),
      "stalled result word changed")

   // a click result always carries a button color
   `PMCT_ASSERT_SAME(a_click_color, clock, reset,
      rsp_valid && rsp_outcome == pmct_pkg::OUTCOME_CLICK,
      rsp_cursor_color == pmct_pkg::COLOR_LEFT || rsp_cursor_color == pmct_pkg::COLOR_RIGHT
         || rsp_cursor_color == pmct_pkg::COLOR_MIDDLE,
      "click result without button color")

   // drop non-mouse bytes without a result
   `PMCT_ASSERT_NEXT(a_aux_drop, clock, reset,
      req_valid && req_ready && !req_from_aux && !rsp_valid, !rsp_valid,
      "result from a non-mouse byte")

   // an empty result register never blocks input
   `PMCT_ASSERT_SAME(a_ready_empty, clock, reset, !rsp_valid, req_ready,
      "input stalled with no result pending")

endmodule

bind ps2_mouse_packet_cursor_tracker_core pmct_checker u_pmct_checker (.*);

`default_nettype wire
